// ===== design/tgad_pkg.sv =====
package tgad_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // configuration register indexes
    localparam int REG_COUNT      = 4;
    localparam int REG_IDX_W      = $clog2(REG_COUNT);
    localparam int CFG_DATA_W     = 13;

    localparam logic [REG_IDX_W-1:0] REG_RLE_MODE     = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_BYTES  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = REG_IDX_W'(3);

    localparam int CMD_DEPTH = 4;

    // one decoded pixel and how many times it repeats
    typedef struct packed {
        logic [7:0] count;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pix_cmd_t;

endpackage

// ===== design/tgad_front.sv =====
module tgad_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 restart,
    input  logic                 hold,
    input  logic                 rle_mode,
    input  logic [2:0]           pixel_bytes,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 cmd_space,
    output logic                 cmd_valid,
    output tgad_pkg::pix_cmd_t   cmd
);

    logic        expect_hdr_reg, expect_hdr_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] asm_reg, asm_next;
    logic [7:0]  remain_reg, remain_next;
    logic        is_run_reg, is_run_next;

    logic        accept;
    logic [2:0]  nbytes;
    logic [31:0] asm_full;
    logic [1:0]  bip_inc;
    logic        complete;
    logic [7:0]  b0, b1, b2, b3;

    assign in_stall = hold || !cmd_space;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (pixel_bytes < 3'd2)
            nbytes = 3'd2;
        else if (pixel_bytes > 3'd4)
            nbytes = 3'd4;
        else
            nbytes = pixel_bytes;
    end

    assign asm_full = asm_reg | (32'(data_byte) << {bip_reg, 3'b000});
    assign bip_inc  = bip_reg + 2'd1;
    assign complete = (bip_inc == 2'd0) || ({1'b0, bip_inc} >= nbytes);

    assign b0 = asm_full[7:0];
    assign b1 = asm_full[15:8];
    assign b2 = asm_full[23:16];
    assign b3 = asm_full[31:24];

    always_comb
    begin
        expect_hdr_next = expect_hdr_reg;
        bip_next        = bip_reg;
        asm_next        = asm_reg;
        remain_next     = remain_reg;
        is_run_next     = is_run_reg;
        cmd_valid       = 1'b0;
        cmd             = '0;

        case (nbytes)
            3'd4:
            begin
                cmd.red   = b2;
                cmd.green = b1;
                cmd.blue  = b0;
                cmd.alpha = b3;
            end
            3'd3:
            begin
                cmd.red   = b2;
                cmd.green = b1;
                cmd.blue  = b0;
                cmd.alpha = 8'hff;
            end
            default:
            begin
                // 5-5-5 with the top bit as alpha
                cmd.red   = {b1[6:2], 3'b000};
                cmd.green = {b1[1:0], b0[7:5], 3'b000};
                cmd.blue  = {b0[4:0], 3'b000};
                cmd.alpha = b1 & 8'h80;
            end
        endcase
        cmd.count = 8'd1;

        if (restart)
        begin
            expect_hdr_next = rle_mode;
            bip_next        = 2'd0;
            asm_next        = '0;
            remain_next     = '0;
            is_run_next     = 1'b0;
        end
        else if (accept)
        begin
            if (rle_mode && expect_hdr_reg)
            begin
                remain_next     = {1'b0, data_byte[6:0]} + 8'd1;
                is_run_next     = data_byte[7];
                expect_hdr_next = 1'b0;
                bip_next        = 2'd0;
                asm_next        = '0;
            end
            else if (!complete)
            begin
                asm_next = asm_full;
                bip_next = bip_inc;
            end
            else
            begin
                asm_next  = '0;
                bip_next  = 2'd0;
                cmd_valid = 1'b1;
                if (rle_mode)
                begin
                    if (is_run_reg)
                    begin
                        cmd.count   = remain_reg;
                        remain_next = '0;
                    end
                    else if (remain_reg != 8'd0)
                    begin
                        remain_next = remain_reg - 8'd1;
                    end
                    if (remain_next == 8'd0)
                        expect_hdr_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_hdr_reg <= 1'b0;
            bip_reg        <= 2'd0;
            asm_reg        <= '0;
            remain_reg     <= '0;
            is_run_reg     <= 1'b0;
        end
        else
        begin
            expect_hdr_reg <= expect_hdr_next;
            bip_reg        <= bip_next;
            asm_reg        <= asm_next;
            remain_reg     <= remain_next;
            is_run_reg     <= is_run_next;
        end
    end

endmodule

// ===== design/tgad_cmd_fifo.sv =====
module tgad_cmd_fifo
#(
    parameter int DEPTH = tgad_pkg::CMD_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 flush,
    input  logic                 push,
    input  tgad_pkg::pix_cmd_t   push_data,
    output logic                 space,
    input  logic                 pop,
    output logic                 valid,
    output tgad_pkg::pix_cmd_t   pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    tgad_pkg::pix_cmd_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] fill_reg;
    logic            do_push, do_pop;

    assign space    = (fill_reg != CNTW'(DEPTH));
    assign valid    = (fill_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && space;
    assign do_pop   = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else if (flush)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + CNTW'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - CNTW'(1);
        end
    end

endmodule

// ===== design/tgad_back.sv =====
module tgad_back
#(
    parameter int MAX_WIDTH  = tgad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tgad_pkg::DEF_MAX_HEIGHT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       width_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      height_eff,
    input  logic                                 cmd_valid,
    input  tgad_pkg::pix_cmd_t                   cmd,
    output logic                                 cmd_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [23:0]                          position,
    output logic [7:0]                           run_length,
    output logic [7:0]                           red,
    output logic [7:0]                           green,
    output logic [7:0]                           blue,
    output logic [7:0]                           alpha,
    output logic                                 last_segment
);

    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam longint AREA = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int RBW     = (AREA > 2) ? $clog2(AREA) : 1;
    localparam int LW      = (WW > 8) ? WW : 8;
    localparam int CMPW    = (RBW > WW) ? RBW : WW;

    tgad_pkg::pix_cmd_t cur_reg, cur_next;
    logic               have_reg, have_next;
    logic [CW-1:0]      column_reg, column_next;
    logic [RBW-1:0]     row_base_reg, row_base_next;
    logic               done_reg, done_next;

    logic               out_valid_reg, out_valid_next;
    logic [23:0]        pos_reg, pos_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         red_reg, green_reg, blue_reg, alpha_reg;
    logic               last_reg, last_next;

    logic [WW-1:0]      avail;
    logic [7:0]         seg_len;
    logic [WW-1:0]      col_end;
    logic               wrap;
    logic               top_row;
    logic               seg_last;
    logic               load_out;
    logic               emit;
    logic               finish;
    logic [HW-1:0]      height_m1;
    logic [RBW-1:0]     row_init;
    logic [RBW-1:0]     pos_full;

    assign height_m1 = height_eff - HW'(1);
    assign row_init  = RBW'(height_m1) * RBW'(width_eff);

    assign avail    = width_eff - WW'(column_reg);
    assign seg_len  = (LW'(cur_reg.count) < LW'(avail)) ? cur_reg.count : 8'(avail);
    assign col_end  = WW'(column_reg) + WW'(seg_len);
    assign wrap     = (col_end == width_eff);
    assign top_row  = (CMPW'(row_base_reg) < CMPW'(width_eff));
    // last segment of this command: its pixels run out, or the image fills up when the top row wraps
    assign seg_last = (seg_len == cur_reg.count) || (wrap && top_row);
    assign pos_full = row_base_reg + RBW'(column_reg);

    assign load_out = !out_valid_reg || !out_stall;
    assign emit     = have_reg && !done_reg && load_out;
    // commands that arrive after the image is full are dropped
    assign finish   = have_reg && (done_reg || (emit && seg_last));
    assign cmd_pop  = !restart && cmd_valid && (!have_reg || finish);

    always_comb
    begin
        cur_next       = cur_reg;
        have_next      = have_reg;
        column_next    = column_reg;
        row_base_next  = row_base_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        last_next      = last_reg;

        if (restart)
        begin
            have_next      = 1'b0;
            column_next    = '0;
            row_base_next  = row_init;
            done_next      = 1'b0;
            out_valid_next = 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_next = 1'b0;
            if (emit)
            begin
                out_valid_next = 1'b1;
                pos_next       = 24'(pos_full);
                len_next       = seg_len;
                last_next      = seg_last;
                cur_next.count = cur_reg.count - seg_len;
                if (wrap)
                begin
                    column_next = '0;
                    if (top_row)
                        done_next = 1'b1;
                    else
                        row_base_next = row_base_reg - RBW'(width_eff);
                end
                else
                begin
                    column_next = CW'(col_end);
                end
            end
            if (finish)
                have_next = 1'b0;
            if (cmd_pop)
            begin
                cur_next  = cmd;
                have_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            column_reg    <= '0;
            row_base_reg  <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_reg      <= have_next;
            column_reg    <= column_next;
            row_base_reg  <= row_base_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pos_reg  <= pos_next;
        len_reg  <= len_next;
        last_reg <= last_next;
        if (emit)
        begin
            red_reg   <= cur_reg.red;
            green_reg <= cur_reg.green;
            blue_reg  <= cur_reg.blue;
            alpha_reg <= cur_reg.alpha;
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = pos_reg;
    assign run_length   = len_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign last_segment = last_reg;

endmodule

// ===== design/tga_image_data_decoder.sv =====
// TGA image-data decoder for true-colour data, raw or run-length packed. Software
// parses the header and loads the four registers; image-data bytes then stream in,
// one per beat, and each result beat is one same-colour segment inside one row
// (position, length, RGBA), rows filled bottom-up. A byte is taken every cycle while
// the four-entry pixel queue has room. The segment generator turns each queued pixel
// into the row segments it covers (up to 33 for a 128-pixel run), so long runs fill
// the queue and then stall the input until the segments drain. Any register write
// restarts the image; the block takes no byte while cfg_we or the restart register
// behind it is set, while the start row is recomputed.
module tga_image_data_decoder
#(
    parameter int MAX_WIDTH  = tgad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tgad_pkg::DEF_MAX_HEIGHT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tgad_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [tgad_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [23:0]                         position,
    output logic [7:0]                          run_length,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    output logic [7:0]                          alpha,
    output logic                                last_segment
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic        rle_mode_reg;
    logic [2:0]  pixel_bytes_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic        restart_reg;

    logic [16:0] w_ext, h_ext, w_clamp, h_clamp;
    logic [WW-1:0] width_eff;
    logic [HW-1:0] height_eff;

    logic               push;
    tgad_pkg::pix_cmd_t push_data;
    logic               space;
    logic               pop;
    logic               q_valid;
    tgad_pkg::pix_cmd_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg     <= 1'b0;
            pixel_bytes_reg  <= 3'd4;
            image_width_reg  <= 13'd4;
            image_height_reg <= 13'd1;
            restart_reg      <= 1'b0;
        end
        else
        begin
            restart_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_index)
                    tgad_pkg::REG_RLE_MODE:     rle_mode_reg     <= cfg_data[0];
                    tgad_pkg::REG_PIXEL_BYTES:  pixel_bytes_reg  <= cfg_data[2:0];
                    tgad_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[12:0];
                    tgad_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[12:0];
                    default:                    rle_mode_reg     <= rle_mode_reg;
                endcase
            end
        end
    end

    // clamp the surface size to at least 4x1 and to what the row and column counters can hold
    assign w_ext = 17'(image_width_reg);
    assign h_ext = 17'(image_height_reg);

    always_comb
    begin
        if (w_ext < 17'd4)
            w_clamp = 17'd4;
        else if (w_ext > 17'(MAX_WIDTH))
            w_clamp = 17'(MAX_WIDTH);
        else
            w_clamp = w_ext;
        if (h_ext < 17'd1)
            h_clamp = 17'd1;
        else if (h_ext > 17'(MAX_HEIGHT))
            h_clamp = 17'(MAX_HEIGHT);
        else
            h_clamp = h_ext;
    end

    assign width_eff  = WW'(w_clamp);
    assign height_eff = HW'(h_clamp);

    tgad_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart_reg),
        .hold        (restart_reg || cfg_we),
        .rle_mode    (rle_mode_reg),
        .pixel_bytes (pixel_bytes_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .cmd_space   (space),
        .cmd_valid   (push),
        .cmd         (push_data)
    );

    tgad_cmd_fifo #(.DEPTH(tgad_pkg::CMD_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (restart_reg),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .pop       (pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    tgad_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart_reg),
        .width_eff    (width_eff),
        .height_eff   (height_eff),
        .cmd_valid    (q_valid),
        .cmd          (q_data),
        .cmd_pop      (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position     (position),
        .run_length   (run_length),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .last_segment (last_segment)
    );

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_SETTLE   = 40;
    localparam int END_SETTLE    = 50;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 95;
    localparam int HOLD_BUDGET   = 30;

    // receiver stall styles
    localparam int STALL_NONE    = 0;
    localparam int STALL_RANDOM  = 1;
    localparam int STALL_PATTERN = 2;

    typedef struct packed {
        logic [23:0] position;
        logic [7:0]  run_length;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_segment;
    } segment_t;

    typedef enum logic {ROW_DATA, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [tgad_pkg::REG_IDX_W-1:0]   reg_idx;
        logic [tgad_pkg::CFG_DATA_W-1:0]  reg_val;
        logic [7:0]                       data;
        logic                             typed;
        segment_t                         seg;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [tgad_pkg::REG_IDX_W-1:0]   cfg_index = '0;
    logic [tgad_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [7:0]                       data_byte = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [23:0]                      position;
    logic [7:0]                       run_length;
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;
    logic [7:0]                       alpha;
    logic                             last_segment;

    tga_image_data_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position     (position),
        .run_length   (run_length),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .last_segment (last_segment)
    );

    always #1 clk = ~clk;

    // decoder shadow: registers and image fill state
    logic           cfg_rle;
    logic [2:0]     cfg_pix;
    logic [12:0]    cfg_w;
    logic [12:0]    cfg_h;
    logic           hdr_pending;
    logic [1:0]     byte_idx;
    logic [31:0]    assembly;
    logic [7:0]     pkt_left;
    logic           pkt_run;
    int unsigned    fill_col;
    int unsigned    fill_row_base;
    logic           img_full;

    segment_t       fresh_segs[$];
    segment_t       pending_segments[$];
    stim_row_t      directed_rows[$];

    int             mismatches = 0;
    int             cycle_count = 0;
    int             burst_left = 0;
    logic           hold_req = 1'b0;

    function automatic int unsigned eff_width();
        if (cfg_w < 4)
            return 4;
        if (cfg_w > tgad_pkg::DEF_MAX_WIDTH)
            return tgad_pkg::DEF_MAX_WIDTH;
        return cfg_w;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_h < 1)
            return 1;
        if (cfg_h > tgad_pkg::DEF_MAX_HEIGHT)
            return tgad_pkg::DEF_MAX_HEIGHT;
        return cfg_h;
    endfunction

    function automatic int unsigned eff_pixel_bytes();
        if (cfg_pix < 2)
            return 2;
        if (cfg_pix > 4)
            return 4;
        return cfg_pix;
    endfunction

    function automatic void restart_image();
        hdr_pending   = cfg_rle;
        byte_idx      = '0;
        assembly      = '0;
        pkt_left      = '0;
        pkt_run       = 1'b0;
        fill_col      = 0;
        fill_row_base = (eff_height() - 1) * eff_width();
        img_full      = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [tgad_pkg::REG_IDX_W-1:0] idx,
                                      input logic [tgad_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            tgad_pkg::REG_RLE_MODE:     cfg_rle = val[0];
            tgad_pkg::REG_PIXEL_BYTES:  cfg_pix = val[2:0];
            tgad_pkg::REG_IMAGE_WIDTH:  cfg_w   = val[12:0];
            tgad_pkg::REG_IMAGE_HEIGHT: cfg_h   = val[12:0];
            default:                    return;
        endcase
        restart_image();
    endfunction

    // split count pixels of one colour into row segments
    function automatic void place_segments(input int unsigned count, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b,
                                           input logic [7:0] a);
        int unsigned w;
        int unsigned avail;
        int unsigned len;
        segment_t    s;
        w = eff_width();
        while (count > 0 && !img_full)
        begin
            avail          = w - fill_col;
            len            = (count < avail) ? count : avail;
            s.position     = 24'(fill_row_base + fill_col);
            s.run_length   = 8'(len);
            s.red          = r;
            s.green        = g;
            s.blue         = b;
            s.alpha        = a;
            s.last_segment = 1'b0;
            fresh_segs.push_back(s);
            fill_col += len;
            count    -= len;
            if (fill_col >= w)
            begin
                fill_col = 0;
                if (fill_row_base < w)
                    img_full = 1'b1;
                else
                    fill_row_base -= w;
            end
        end
        if (fresh_segs.size() > 0)
        begin
            s = fresh_segs.pop_back();
            s.last_segment = 1'b1;
            fresh_segs.push_back(s);
        end
    endfunction

    // advance the shadow by one accepted byte; results land in fresh_segs
    function automatic void decode_byte(input logic [7:0] b);
        int unsigned nb;
        int unsigned count;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  bl;
        logic [7:0]  a;
        fresh_segs.delete();
        nb = eff_pixel_bytes();
        if (img_full)
            return;
        if (cfg_rle && hdr_pending)
        begin
            pkt_left    = {1'b0, b[6:0]} + 8'd1;
            pkt_run     = b[7];
            hdr_pending = 1'b0;
            byte_idx    = '0;
            assembly    = '0;
            return;
        end
        assembly = assembly | (32'(b) << (8 * byte_idx));
        byte_idx = byte_idx + 2'd1;
        if (byte_idx < nb && byte_idx != 0)
            return;
        b0 = assembly[7:0];
        b1 = assembly[15:8];
        if (nb == 2)
        begin
            r  = {b1[6:2], 3'b000};
            g  = {b1[1:0], b0[7:5], 3'b000};
            bl = {b0[4:0], 3'b000};
            a  = {b1[7], 7'b0};
        end
        else
        begin
            r  = assembly[23:16];
            g  = b1;
            bl = b0;
            a  = (nb == 4) ? assembly[31:24] : 8'hFF;
        end
        byte_idx = '0;
        assembly = '0;
        count    = 1;
        if (cfg_rle)
        begin
            if (pkt_run)
            begin
                count    = pkt_left;
                pkt_left = '0;
            end
            else if (pkt_left > 0)
            begin
                pkt_left = pkt_left - 8'd1;
            end
            if (pkt_left == 0)
                hdr_pending = 1'b1;
        end
        place_segments(count, r, g, bl, a);
    endfunction

    function automatic segment_t make_seg(input int unsigned pos, input int unsigned len,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a);
        segment_t s;
        s.position     = 24'(pos);
        s.run_length   = 8'(len);
        s.red          = r;
        s.green        = g;
        s.blue         = b;
        s.alpha        = a;
        s.last_segment = 1'b1;
        return s;
    endfunction

    task automatic add_write(input logic [tgad_pkg::REG_IDX_W-1:0] idx,
                             input logic [tgad_pkg::CFG_DATA_W-1:0] val);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic typed, input segment_t seg);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_DATA;
        row.data  = b;
        row.typed = typed;
        row.seg   = seg;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // hold until every expected segment is out, then let the block go quiet
    task automatic settle_block();
        while (pending_segments.size() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [tgad_pkg::REG_IDX_W-1:0] idx,
                             input logic [tgad_pkg::CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        apply_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // offer one beat, idling between bursts; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic typed, input segment_t seg);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        in_valid  = 1'b1;
        data_byte = b;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b);
        if (typed)
            pending_segments.push_back(seg);
        else
            foreach (fresh_segs[i])
                pending_segments.push_back(fresh_segs[i]);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin : seg_monitor
        segment_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_segments.size() == 0)
            begin
                report_mismatch("unexpected segment at position", position, 0);
            end
            else
            begin
                want = pending_segments.pop_front();
                if (position !== want.position)
                    report_mismatch("position", position, want.position);
                if (run_length !== want.run_length)
                    report_mismatch("run_length", run_length, want.run_length);
                if (red !== want.red)
                    report_mismatch("red", red, want.red);
                if (green !== want.green)
                    report_mismatch("green", green, want.green);
                if (blue !== want.blue)
                    report_mismatch("blue", blue, want.blue);
                if (alpha !== want.alpha)
                    report_mismatch("alpha", alpha, want.alpha);
                if (last_segment !== want.last_segment)
                    report_mismatch("last_segment", last_segment, want.last_segment);
            end
        end
    end

    initial
    begin : receiver
        int   span;
        int   style;
        logic hold_done;
        span      = 0;
        style     = STALL_NONE;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (span == 0)
            begin
                span  = $urandom_range(8, 60);
                style = $urandom_range(STALL_NONE, STALL_PATTERN);
            end
            span--;
            case (style)
                STALL_NONE:   out_stall = 1'b0;
                STALL_RANDOM: out_stall = ($urandom_range(0, 2) == 0);
                default:      out_stall = (span % 3) != 0;
            endcase
        end
    end

    initial
    begin : stimulus
        int          phase;
        int          random_items;
        int          phase_items;
        int          budget;
        logic        paused;
        logic        rle_v;
        logic [2:0]  pix_v;
        logic [12:0] w_v;
        logic [12:0] h_v;
        logic [7:0]  b;

        cfg_rle = 1'b0;
        cfg_pix = 3'd4;
        cfg_w   = 13'd4;
        cfg_h   = 13'd1;
        restart_image();

        // 32-bit pixel right after reset, 4x1 surface
        add_byte(8'h01, 1'b0, '0);
        add_byte(8'h02, 1'b0, '0);
        add_byte(8'h03, 1'b0, '0);
        add_byte(8'h84, 1'b1, make_seg(0, 1, 8'h03, 8'h02, 8'h01, 8'h84));
        // 16-bit: all ones, then all zeros
        add_write(tgad_pkg::REG_PIXEL_BYTES, 13'd2);
        add_byte(8'hFF, 1'b0, '0);
        add_byte(8'hFF, 1'b1, make_seg(0, 1, 8'hF8, 8'hF8, 8'hF8, 8'h80));
        add_byte(8'h00, 1'b0, '0);
        add_byte(8'h00, 1'b1, make_seg(1, 1, 8'h00, 8'h00, 8'h00, 8'h00));
        // 24-bit
        add_write(tgad_pkg::REG_PIXEL_BYTES, 13'd3);
        add_byte(8'h11, 1'b0, '0);
        add_byte(8'h22, 1'b0, '0);
        add_byte(8'h33, 1'b1, make_seg(0, 1, 8'h33, 8'h22, 8'h11, 8'hFF));
        // RLE 16-bit: run of 3, raw of 2 whose second pixel falls off the full image
        add_write(tgad_pkg::REG_RLE_MODE, 13'd1);
        add_write(tgad_pkg::REG_PIXEL_BYTES, 13'd2);
        add_byte(8'h82, 1'b0, '0);
        add_byte(8'hE0, 1'b0, '0);
        add_byte(8'h03, 1'b1, make_seg(0, 3, 8'h00, 8'hF8, 8'h00, 8'h00));
        add_byte(8'h01, 1'b0, '0);
        add_byte(8'h1F, 1'b0, '0);
        add_byte(8'h7C, 1'b1, make_seg(3, 1, 8'hF8, 8'h00, 8'hF8, 8'h00));
        add_byte(8'hAA, 1'b0, '0);
        add_byte(8'hBB, 1'b0, '0);
        // one pixel offsets the column, then a 128-pixel run spans 33 segments
        add_write(tgad_pkg::REG_IMAGE_HEIGHT, 13'd40);
        add_byte(8'h00, 1'b0, '0);
        add_byte(8'h34, 1'b0, '0);
        add_byte(8'h12, 1'b0, '0);
        add_byte(8'hFF, 1'b0, '0);
        add_byte(8'h55, 1'b0, '0);
        add_byte(8'hAA, 1'b0, '0);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle_block();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
            begin
                send_byte(directed_rows[i].data, directed_rows[i].typed,
                          directed_rows[i].seg);
            end
        end

        phase        = 0;
        random_items = 0;
        paused       = 1'b0;
        while (random_items < RANDOM_ITEMS)
        begin
            rle_v = ($urandom_range(0, 2) != 0);
            pix_v = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(2, 4));
            w_v   = 13'($urandom_range(4, 16));
            h_v   = 13'($urandom_range(1, 5));
            if ($urandom_range(0, 7) == 0)
                w_v = 13'($urandom_range(0, 3));
            case (phase)
                0:
                begin
                    rle_v = 1'b1;
                    pix_v = 3'd2;
                    w_v   = 13'd4;
                    h_v   = 13'd40;
                end
                1:
                begin
                    w_v   = 13'h1FFF;
                    h_v   = 13'h1FFF;
                    pix_v = 3'd7;
                end
                2:
                begin
                    w_v   = 13'd0;
                    h_v   = 13'd0;
                    pix_v = 3'd0;
                end
                3:
                begin
                    rle_v = 1'b0;
                    pix_v = 3'd4;
                    w_v   = 13'd4096;
                    h_v   = 13'd4096;
                end
                default: ;
            endcase

            settle_block();
            write_reg(tgad_pkg::REG_RLE_MODE, 13'(rle_v));
            write_reg(tgad_pkg::REG_PIXEL_BYTES, 13'(pix_v));
            write_reg(tgad_pkg::REG_IMAGE_WIDTH, w_v);
            write_reg(tgad_pkg::REG_IMAGE_HEIGHT, h_v);
            // hold the output while bytes keep coming so the pixel queue backs up
            if (phase == 0)
                hold_req = 1'b1;

            budget      = (phase == 0) ? HOLD_BUDGET : $urandom_range(12, 30);
            phase_items = 0;
            while (phase_items < budget && !img_full)
            begin
                if (phase == 3 && phase_items >= 10 && !paused)
                begin
                    paused = 1'b1;
                    while (pending_segments.size() != 0)
                        @(negedge clk);
                end
                // packet headers mostly short so raw packets close within the phase
                if (cfg_rle && hdr_pending && (phase == 0 || $urandom_range(0, 4) != 0))
                    b = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 5))};
                else
                    b = 8'($urandom_range(0, 255));
                send_byte(b, 1'b0, '0);
                phase_items++;
            end
            // a couple of bytes past a full image are dropped
            if (img_full)
            begin
                repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                random_items += 2;
            end
            random_items += phase_items;
            phase++;
        end

        while (pending_segments.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
design/tgad_pkg.sv
design/tgad_front.sv
design/tgad_cmd_fifo.sv
design/tgad_back.sv
design/tga_image_data_decoder.sv
bench/testbench.sv
